FILE: rtl/core/xst_pkg.sv
// ----------------------------------------------------------------------------
// xst_pkg
// Shared types and character constants for the XML-style tagger.
// ----------------------------------------------------------------------------
package xst_pkg;

	// Style codes as delivered on the result channel
	typedef enum logic [2:0] {
		CODE_PLAIN   = 3'd0,
		CODE_TAG     = 3'd1,
		CODE_QUOTE   = 3'd2,
		CODE_ATTR    = 3'd3,
		CODE_COMMENT = 3'd4,
		CODE_NEWLINE = 3'd5
	} code_t;

	// Running style kept between bytes (only the four text styles)
	typedef enum logic [1:0] {
		STY_PLAIN = 2'd0,
		STY_TAG   = 2'd1,
		STY_QUOTE = 2'd2,
		STY_ATTR  = 2'd3
	} style_t;

	typedef logic [7:0] byte_t;

	localparam byte_t CH_LT      = 8'h3C; // '<'
	localparam byte_t CH_GT      = 8'h3E; // '>'
	localparam byte_t CH_DQUOTE  = 8'h22; // '"'
	localparam byte_t CH_SPACE   = 8'h20; // ' '
	localparam byte_t CH_EQUAL   = 8'h3D; // '='
	localparam byte_t CH_NEWLINE = 8'h0A; // '\n'
	localparam byte_t CH_SLASH   = 8'h2F; // '/'
	localparam byte_t CH_BANG    = 8'h21; // '!'
	localparam byte_t CH_DASH    = 8'h2D; // '-'

	// Window depth: the byte being styled plus three bytes of lookahead
	localparam int unsigned WIN_DEPTH = 4;

endpackage

FILE: rtl/core/xst_if.sv
// ----------------------------------------------------------------------------
// xst_byte_if / xst_code_if
// Valid/ready channels for text bytes in and style codes out.
// ----------------------------------------------------------------------------
interface xst_byte_if;
	logic          valid;
	logic          ready;
	xst_pkg::byte_t text_byte;
	logic          run_end;

	modport source (output valid, output text_byte, output run_end, input ready);
	modport sink   (input valid, input text_byte, input run_end, output ready);
endinterface

interface xst_code_if;
	logic          valid;
	logic          ready;
	logic [2:0]    style_code;
	logic          run_done;

	modport source (output valid, output style_code, output run_done, input ready);
	modport sink   (input valid, input style_code, input run_done, output ready);
endinterface

FILE: rtl/core/xml_style_tagger_core.sv
// A byte's code is registered at the request that brings the third
// byte behind it and is valid the next cycle; a run's final byte is followed
// by its 1..4 held codes, the first registered after that request once the output is free.
// Throughput: one byte per cycle inside a run while the output takes codes; the final
// byte of a run holds off new requests until all its held bytes have been flushed.
// Reset (arst_n low) clears lookahead, history, style and flags, as each run end does.
// ----------------------------------------------------------------------------
// xml_style_tagger_core
// Styles a byte stream of XML-like text with three bytes of lookahead for
// comment-start detection; results go out through a registered output stage.
// ----------------------------------------------------------------------------
module xml_style_tagger_core (
	input  logic            clk,
	input  logic            arst_n,
	xst_byte_if.sink        byte_in,
	xst_code_if.source      style_out
);

	// Lookahead buffer: up to three held bytes, four during a flush
	xst_pkg::byte_t buf_q [xst_pkg::WIN_DEPTH];
	logic [2:0]     cnt_q;
	logic           flush_q;

	// Styling state
	xst_pkg::byte_t hist0_q, hist1_q;
	xst_pkg::style_t style_q;
	logic           tag_q;
	logic           cmt_q;

	// Output register
	logic           out_valid_q;
	xst_pkg::code_t out_code_q;
	logic           out_done_q;

	logic           out_free;
	logic           in_acc;
	logic           fire_norm, fire_flush, fire;
	logic           flush_last;

	// Styling unit inputs and outputs
	xst_pkg::byte_t  c, w1, w2, w3;
	logic            full;
	logic            cmt_start;
	xst_pkg::code_t  code_d;
	xst_pkg::style_t style_d;
	logic            tag_d, cmt_d;

	// Handshake
	assign out_free      = !out_valid_q || style_out.ready;
	assign byte_in.ready = !flush_q && out_free;
	assign in_acc        = byte_in.valid && byte_in.ready;
	assign fire_norm     = in_acc && !byte_in.run_end && (cnt_q == 3'd3);
	assign fire_flush    = flush_q && out_free;
	assign fire          = fire_norm || fire_flush;
	assign flush_last    = fire_flush && (cnt_q == 3'd1);

	// Window selection: flush styles from the buffer alone
	always_comb begin
		c    = buf_q[0];
		w1   = buf_q[1];
		w2   = buf_q[2];
		w3   = flush_q ? buf_q[3] : byte_in.text_byte;
		full = flush_q ? (cnt_q == 3'd4) : 1'b1;
	end

	assign cmt_start = full && (c == xst_pkg::CH_LT) && (w1 == xst_pkg::CH_BANG) &&
		(w2 == xst_pkg::CH_DASH) && (w3 == xst_pkg::CH_DASH);

	// Style one byte and work out the next state
	always_comb begin
		code_d  = xst_pkg::CODE_PLAIN;
		style_d = style_q;
		tag_d   = tag_q;
		cmt_d   = cmt_q;
		if (!cmt_q) begin
			if (cmt_start) begin
				code_d = xst_pkg::CODE_COMMENT;
				cmt_d  = 1'b1;
			end else begin
				case (c)
					xst_pkg::CH_LT: begin
						code_d  = xst_pkg::CODE_TAG;
						style_d = xst_pkg::STY_TAG;
						tag_d   = 1'b1;
					end
					xst_pkg::CH_GT: begin
						code_d  = xst_pkg::CODE_TAG;
						style_d = xst_pkg::STY_PLAIN;
						tag_d   = 1'b0;
					end
					xst_pkg::CH_DQUOTE: begin
						code_d  = xst_pkg::CODE_QUOTE;
						style_d = (style_q == xst_pkg::STY_QUOTE) ?
							xst_pkg::STY_PLAIN : xst_pkg::STY_QUOTE;
					end
					xst_pkg::CH_SPACE: begin
						code_d = xst_pkg::CODE_PLAIN;
						if (style_q != xst_pkg::STY_QUOTE) begin
							style_d = tag_q ? xst_pkg::STY_ATTR : xst_pkg::STY_PLAIN;
						end
					end
					xst_pkg::CH_EQUAL: begin
						code_d = xst_pkg::CODE_PLAIN;
					end
					xst_pkg::CH_NEWLINE: begin
						code_d  = xst_pkg::CODE_NEWLINE;
						style_d = xst_pkg::STY_PLAIN;
					end
					xst_pkg::CH_SLASH: begin
						code_d = xst_pkg::CODE_TAG;
					end
					default: begin
						code_d = xst_pkg::code_t'({1'b0, style_q});
					end
				endcase
			end
		end else begin
			code_d = xst_pkg::CODE_COMMENT;
			// "-->" closes the comment; history holds the two bytes before c
			if ((c == xst_pkg::CH_GT) && (hist0_q == xst_pkg::CH_DASH) &&
				(hist1_q == xst_pkg::CH_DASH)) begin
				style_d = xst_pkg::STY_PLAIN;
				cmt_d   = 1'b0;
			end
		end
	end

	// Lookahead buffer payload
	always_ff @(posedge clk) begin
		if (in_acc) begin
			if (fire_norm) begin
				buf_q[0] <= buf_q[1];
				buf_q[1] <= buf_q[2];
				buf_q[2] <= byte_in.text_byte;
			end else begin
				buf_q[cnt_q[1:0]] <= byte_in.text_byte;
			end
		end else if (fire_flush) begin
			buf_q[0] <= buf_q[1];
			buf_q[1] <= buf_q[2];
			buf_q[2] <= buf_q[3];
		end
	end

	// Buffer count and flush control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= 3'd0;
			flush_q <= 1'b0;
		end else if (in_acc) begin
			if (byte_in.run_end) begin
				flush_q <= 1'b1;
			end
			if (!fire_norm) begin
				cnt_q <= cnt_q + 3'd1;
			end
		end else if (fire_flush) begin
			cnt_q <= cnt_q - 3'd1;
			if (flush_last) begin
				flush_q <= 1'b0;
			end
		end
	end

	// Styling state; cleared after the last byte of a run
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist0_q <= '0;
			hist1_q <= '0;
			style_q <= xst_pkg::STY_PLAIN;
			tag_q   <= 1'b0;
			cmt_q   <= 1'b0;
		end else if (flush_last) begin
			hist0_q <= '0;
			hist1_q <= '0;
			style_q <= xst_pkg::STY_PLAIN;
			tag_q   <= 1'b0;
			cmt_q   <= 1'b0;
		end else if (fire) begin
			hist1_q <= hist0_q;
			hist0_q <= c;
			style_q <= style_d;
			tag_q   <= tag_d;
			cmt_q   <= cmt_d;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (style_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_code_q <= code_d;
			out_done_q <= flush_last;
		end
	end

	assign style_out.valid      = out_valid_q;
	assign style_out.style_code = out_code_q;
	assign style_out.run_done   = out_done_q;

endmodule

FILE: verif/tb_xml_style_tagger_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_xml_style_tagger_core
// Drives runs of XML-like text into the tagger and checks every style code
// against a cycle-free predictor of the lookahead, comment and tag tracking.
// Both channels idle at random. The code side holds off once for a long
// stretch so that the input backs up.
// ----------------------------------------------------------------------------
module tb_xml_style_tagger_core;
	import xst_pkg::*;

	localparam int RANDOM_BYTES = 380;
	localparam int CALM_AFTER   = 320;
	localparam int STALL_LIMIT  = 3000;
	localparam int HOLD_CYCLES  = 80;
	localparam int HOLD_AT      = 120;

	// One expected code for one text byte
	typedef struct {
		code_t code;
		bit    done;
	} styled_byte_t;

	// Predicts style codes and checks the codes coming out of the block
	class style_tracker;
		byte_t        held[$];
		byte_t        hist0, hist1;
		style_t       sty;
		bit           in_tag, in_cmt;
		styled_byte_t pending[$];
		int           errors;

		function new();
			errors = 0;
			clear();
		endfunction

		function void clear();
			held.delete();
			hist0 = '0;
			hist1 = '0;
			sty = STY_PLAIN;
			in_tag = 1'b0;
			in_cmt = 1'b0;
		endfunction

		// Style win[0]; n bytes of the window are real (1..4)
		function code_t style_byte(byte_t win[4], int n);
			byte_t c;
			code_t code;
			bit opens;
			c = win[0];
			if (!in_cmt) begin
				opens = (n >= 4) && c == CH_LT && win[1] == CH_BANG &&
					win[2] == CH_DASH && win[3] == CH_DASH;
				if (opens) begin
					code = CODE_COMMENT;
					in_cmt = 1'b1;
				end else begin
					case (c)
						CH_LT: begin
							code = CODE_TAG;
							sty = STY_TAG;
							in_tag = 1'b1;
						end
						CH_GT: begin
							code = CODE_TAG;
							sty = STY_PLAIN;
							in_tag = 1'b0;
						end
						CH_DQUOTE: begin
							code = CODE_QUOTE;
							sty = (sty == STY_QUOTE) ? STY_PLAIN : STY_QUOTE;
						end
						CH_SPACE: begin
							code = CODE_PLAIN;
							if (sty != STY_QUOTE)
								sty = in_tag ? STY_ATTR : STY_PLAIN;
						end
						CH_EQUAL:   code = CODE_PLAIN;
						CH_NEWLINE: begin
							code = CODE_NEWLINE;
							sty = STY_PLAIN;
						end
						CH_SLASH:   code = CODE_TAG;
						default:    code = code_t'({1'b0, sty});
					endcase
				end
			end else begin
				code = CODE_COMMENT;
				// closing "-->" may reuse the dashes of the opener
				if (c == CH_GT && hist0 == CH_DASH && hist1 == CH_DASH) begin
					sty = STY_PLAIN;
					in_cmt = 1'b0;
				end
			end
			hist1 = hist0;
			hist0 = c;
			return code;
		endfunction

		// Accepted text byte: style whatever it releases
		function void take_byte(byte_t b, bit last);
			byte_t win[4];
			styled_byte_t item;
			int n;
			held.push_back(b);
			if (!last) begin
				if (held.size() == WIN_DEPTH) begin
					for (int k = 0; k < 4; k++)
						win[k] = held[k];
					item.code = style_byte(win, 4);
					item.done = 1'b0;
					pending.push_back(item);
					void'(held.pop_front());
				end
			end else begin
				// flush: bytes past the end of the run never match
				n = held.size();
				for (int k = 0; k < n; k++) begin
					for (int j = 0; j < 4; j++)
						win[j] = (k + j < n) ? held[k + j] : 8'h00;
					item.code = style_byte(win, n - k);
					item.done = (k == n - 1);
					pending.push_back(item);
				end
				clear();
			end
		endfunction

		function void match_code(logic [2:0] code, logic done);
			styled_byte_t want;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("%0t: unexpected code %0d done %0b", $realtime, code, done);
				return;
			end
			want = pending.pop_front();
			if (code !== want.code || done !== want.done) begin
				errors++;
				if (errors <= 10)
					$display("%0t: code exp %0d act %0d, done exp %0b act %0b",
						$realtime, want.code, code, want.done, done);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	xst_byte_if byte_ch();
	xst_code_if code_ch();

	xml_style_tagger_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.byte_in  (byte_ch),
		.style_out(code_ch)
	);

	style_tracker tracker = new();

	int    bytes_taken = 0;
	int    random_sent = 0;
	bit    calm = 1'b0;
	bit    hold_active = 1'b0;
	bit    hold_done = 1'b0;
	int    idle_cycles = 0;
	byte_t run_buf[$];

	// Clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Monitor: note requests, check codes
	always @(posedge clk) begin
		if (arst_n) begin
			if (byte_ch.valid && byte_ch.ready) begin
				tracker.take_byte(byte_ch.text_byte, byte_ch.run_end);
				bytes_taken++;
			end
			if (code_ch.valid && code_ch.ready)
				tracker.match_code(code_ch.style_code, code_ch.run_done);
		end
	end

	// Watchdog on cycles with no handshake on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((byte_ch.valid && byte_ch.ready) || (code_ch.valid && code_ch.ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	// Code side: random stalls, one long hold-off
	initial begin
		code_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (!hold_done && bytes_taken >= HOLD_AT) begin
				code_ch.ready <= 1'b0;
				hold_active = 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_active = 1'b0;
				hold_done = 1'b1;
			end else if (!calm && $urandom_range(0, 4) == 0) begin
				code_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 18)) @(posedge clk);
			end
			code_ch.ready <= 1'b1;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	end

	// Offer one byte, maybe after an idle burst; return once it is taken
	task automatic send_byte(byte_t b, bit last);
		int gap;
		gap = 0;
		if (!calm && !hold_active && $urandom_range(0, 4) == 0)
			gap = $urandom_range(1, 18);
		if (gap > 0) begin
			byte_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		byte_ch.valid     <= 1'b1;
		byte_ch.text_byte <= b;
		byte_ch.run_end   <= last;
		@(posedge clk);
		while (!byte_ch.ready)
			@(posedge clk);
	endtask

	task automatic send_text(string s, bit end_run);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i], end_run && (i == s.len() - 1));
	endtask

	function automatic void push_str(string s);
		for (int i = 0; i < s.len(); i++)
			run_buf.push_back(s[i]);
	endfunction

	// Append one random piece of markup to the run being built
	function automatic void add_piece();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 10)
			push_str("<!--");
		else if (pick < 20)
			push_str("-->");
		else if (pick < 28)
			run_buf.push_back(CH_LT);
		else if (pick < 36)
			run_buf.push_back(CH_GT);
		else if (pick < 44)
			run_buf.push_back(CH_DQUOTE);
		else if (pick < 52)
			run_buf.push_back(CH_SPACE);
		else if (pick < 57)
			run_buf.push_back(CH_EQUAL);
		else if (pick < 62)
			run_buf.push_back(CH_NEWLINE);
		else if (pick < 67)
			run_buf.push_back(CH_SLASH);
		else if (pick < 73)
			run_buf.push_back(CH_DASH);
		else if (pick < 76)
			run_buf.push_back(CH_BANG);
		else if (pick < 90)
			run_buf.push_back(byte_t'($urandom_range(8'h61, 8'h7A)));
		else
			run_buf.push_back(byte_t'($urandom_range(0, 255)));
	endfunction

	// Stimulus
	initial begin
		int run_len;
		arst_n            <= 1'b0;
		byte_ch.valid     <= 1'b0;
		byte_ch.text_byte <= '0;
		byte_ch.run_end   <= 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: one-byte run, overlapping comment open/close,
		// a full tag with quoted attribute, opener cut off by the run end
		send_byte(8'hFF, 1'b1);
		send_text("<!-->", 1'b1);
		send_text("<p q=\"r s\"/>\n", 1'b1);
		send_byte(8'h00, 1'b0);
		send_text("<!-", 1'b1);

		// random runs, mostly short markup fragments
		while (random_sent < RANDOM_BYTES) begin
			run_buf.delete();
			if ($urandom_range(0, 9) == 0)
				run_len = 1;
			else
				run_len = $urandom_range(2, 24);
			while (run_buf.size() < run_len)
				add_piece();
			foreach (run_buf[i]) begin
				if (random_sent >= CALM_AFTER)
					calm = 1'b1;
				send_byte(run_buf[i], i == run_buf.size() - 1);
				random_sent++;
			end
		end
		byte_ch.valid   <= 1'b0;
		byte_ch.run_end <= 1'b0;

		while (tracker.pending.size() != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);

		if (tracker.errors == 0 && tracker.pending.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
